@@ rtl/binary_frame_deframer_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the binary frame deframer
// Concurrent assertion wrappers that can be compiled out as a group.
// ----------------------------------------------------------------------------
`ifndef BINARY_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define BINARY_FRAME_DEFRAMER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define BFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define BFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");
`else
`define BFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/bfd_pkg.sv @@
// ----------------------------------------------------------------------------
// Binary frame deframer package
// Shared types and constants of the front parser, command queue and back end.
// ----------------------------------------------------------------------------
package bfd_pkg;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_STD    = 2'd1,
    ST_BAD_FOOTER = 2'd2,
    ST_TOO_LARGE  = 2'd3
  } status_e;

  typedef enum logic [8:0] {
    PH_HUNT    = 9'b000000001,
    PH_HDR2    = 9'b000000010,
    PH_SIZE1   = 9'b000000100,
    PH_SIZE2   = 9'b000001000,
    PH_TYPE    = 9'b000010000,
    PH_PAYLOAD = 9'b000100000,
    PH_STD     = 9'b001000000,
    PH_FOOT1   = 9'b010000000,
    PH_FOOT2   = 9'b100000000
  } phase_e;

  localparam logic [7:0] HDR_BYTE1 = 8'hFE;
  localparam logic [7:0] HDR_BYTE2 = 8'hFD;
  localparam logic [7:0] STD_BYTE  = 8'h00;
  localparam logic [7:0] FTR_BYTE1 = 8'hFD;
  localparam logic [7:0] FTR_BYTE2 = 8'hFE;

  // Wide enough for any supported payload count (up to 64).
  localparam int unsigned SIZE_W = 7;

  typedef struct packed {
    status_e           status;
    logic [7:0]        frame_type;
    logic [SIZE_W-1:0] size;
  } cmd_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] frame_type;
    logic [5:0] payload_size;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [4:0] byte_position;
    logic       last;
  } result_t;

endpackage

@@ rtl/bfd_front.sv @@
// ----------------------------------------------------------------------------
// Deframer front end
// Parses the byte stream, writes payload bytes to the buffer and posts one
// command per finished or broken frame.
// ----------------------------------------------------------------------------
module bfd_front #(
  parameter int unsigned MAX_PAYLOAD = 32,
  parameter int unsigned CW          = 6,
  parameter int unsigned AW          = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic [7:0]           rx_byte_i,
  input  logic                 cmdq_full_i,
  input  logic                 back_busy_i,
  output logic                 cmd_push_o,
  output bfd_pkg::cmd_t        cmd_o,
  output logic                 wr_en_o,
  output logic [AW-1:0]        wr_addr_o,
  output logic [7:0]           wr_data_o
);

  bfd_pkg::phase_e phase_q, phase_d;
  logic [7:0]    size_hi_q, size_hi_d;
  logic [CW-1:0] size_q, size_d;
  logic [7:0]    type_q, type_d;
  logic [CW-1:0] fill_q, fill_d;
  logic          foot_ok_q, foot_ok_d;
  logic [CW-1:0] fill_inc;
  logic          fire;

  // The buffer is shared with the back end, so payload bytes wait while it
  // still reads out the previous frame.
  assign full_o = cmdq_full_i || ((phase_q == bfd_pkg::PH_PAYLOAD) && back_busy_i);
  assign fire   = push_i && !full_o;
  assign fill_inc = CW'(fill_q + 1'b1);

  assign wr_addr_o = fill_q[AW-1:0];
  assign wr_data_o = rx_byte_i;

  always_comb begin
    phase_d    = phase_q;
    size_hi_d  = size_hi_q;
    size_d     = size_q;
    type_d     = type_q;
    fill_d     = fill_q;
    foot_ok_d  = foot_ok_q;
    cmd_push_o = 1'b0;
    cmd_o      = '{status: bfd_pkg::ST_OK, frame_type: 8'h00, size: '0};
    wr_en_o    = 1'b0;
    if (fire) begin
      case (phase_q)
        bfd_pkg::PH_HUNT: begin
          if (rx_byte_i == bfd_pkg::HDR_BYTE1) phase_d = bfd_pkg::PH_HDR2;
        end
        bfd_pkg::PH_HDR2: begin
          phase_d = (rx_byte_i == bfd_pkg::HDR_BYTE2) ? bfd_pkg::PH_SIZE1
                                                      : bfd_pkg::PH_HUNT;
        end
        bfd_pkg::PH_SIZE1: begin
          size_hi_d = rx_byte_i;
          phase_d   = bfd_pkg::PH_SIZE2;
        end
        bfd_pkg::PH_SIZE2: begin
          if ({size_hi_q, rx_byte_i} > 16'(MAX_PAYLOAD)) begin
            cmd_push_o   = 1'b1;
            cmd_o.status = bfd_pkg::ST_TOO_LARGE;
            phase_d      = bfd_pkg::PH_HUNT;
          end else begin
            size_d  = CW'(rx_byte_i);
            phase_d = bfd_pkg::PH_TYPE;
          end
        end
        bfd_pkg::PH_TYPE: begin
          type_d  = rx_byte_i;
          fill_d  = '0;
          phase_d = (size_q == '0) ? bfd_pkg::PH_STD : bfd_pkg::PH_PAYLOAD;
        end
        bfd_pkg::PH_PAYLOAD: begin
          wr_en_o = 1'b1;
          fill_d  = fill_inc;
          if (fill_inc == size_q) begin
            fill_d  = '0;
            phase_d = bfd_pkg::PH_STD;
          end
        end
        bfd_pkg::PH_STD: begin
          if (rx_byte_i != bfd_pkg::STD_BYTE) begin
            cmd_push_o   = 1'b1;
            cmd_o.status = bfd_pkg::ST_BAD_STD;
            phase_d      = bfd_pkg::PH_HUNT;
          end else begin
            phase_d = bfd_pkg::PH_FOOT1;
          end
        end
        bfd_pkg::PH_FOOT1: begin
          foot_ok_d = (rx_byte_i == bfd_pkg::FTR_BYTE1);
          phase_d   = bfd_pkg::PH_FOOT2;
        end
        bfd_pkg::PH_FOOT2: begin
          cmd_push_o = 1'b1;
          phase_d    = bfd_pkg::PH_HUNT;
          if (foot_ok_q && (rx_byte_i == bfd_pkg::FTR_BYTE2)) begin
            cmd_o.frame_type = type_q;
            cmd_o.size       = bfd_pkg::SIZE_W'(size_q);
          end else begin
            cmd_o.status = bfd_pkg::ST_BAD_FOOTER;
          end
        end
        default: begin
          phase_d = bfd_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= bfd_pkg::PH_HUNT;
      size_hi_q <= '0;
      size_q    <= '0;
      type_q    <= '0;
      fill_q    <= '0;
      foot_ok_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      size_hi_q <= size_hi_d;
      size_q    <= size_d;
      type_q    <= type_d;
      fill_q    <= fill_d;
      foot_ok_q <= foot_ok_d;
    end
  end

endmodule

@@ rtl/bfd_cmdq.sv @@
// ----------------------------------------------------------------------------
// Deframer command queue
// Two-entry queue of frame commands between the front and back ends.
// ----------------------------------------------------------------------------
module bfd_cmdq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bfd_pkg::cmd_t data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output bfd_pkg::cmd_t data_o
);

  bfd_pkg::cmd_t entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      count_q <= 2'(count_q + 2'(do_push) - 2'(do_pop));
    end
  end

endmodule

@@ rtl/bfd_back.sv @@
// ----------------------------------------------------------------------------
// Deframer back end
// Holds the payload buffer and turns each frame command into its run of
// result items through a registered read and a two-entry result queue.
// ----------------------------------------------------------------------------
module bfd_back #(
  parameter int unsigned MAX_PAYLOAD = 32,
  parameter int unsigned CW          = 6,
  parameter int unsigned AW          = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic             cmd_valid_i,
  input  bfd_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  output logic             busy_o,
  input  logic             pop_i,
  output logic             empty_o,
  output bfd_pkg::result_t res_o
);

  logic [7:0] mem [MAX_PAYLOAD];

  bfd_pkg::cmd_t    cmd_q;
  logic             active_q;
  logic [CW-1:0]    idx_q;
  logic             s1_valid_q;
  bfd_pkg::result_t s1_res_q;
  logic [7:0]       rdata_q;

  bfd_pkg::result_t fifo_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  logic                      pop_fire, room, issue, is_ok, has_data, is_last;
  logic [bfd_pkg::SIZE_W-1:0] idx_w;
  bfd_pkg::result_t          issue_res, s1_out;

  assign pop_fire = pop_i && (count_q != 2'd0);
  // Issue only when the result is sure to find a free queue slot.
  assign room     = (3'(count_q) + 3'(s1_valid_q)) <= (3'd1 + 3'(pop_fire));
  assign issue    = active_q && room;
  assign is_ok    = (cmd_q.status == bfd_pkg::ST_OK);
  assign has_data = is_ok && (cmd_q.size != '0);
  assign idx_w    = bfd_pkg::SIZE_W'(idx_q);
  assign is_last  = !has_data || (bfd_pkg::SIZE_W'(idx_w + 1'b1) == cmd_q.size);

  assign cmd_pop_o = !active_q && cmd_valid_i;
  assign busy_o    = active_q || cmd_valid_i;

  always_comb begin
    issue_res               = '0;
    issue_res.status        = cmd_q.status;
    issue_res.last          = is_last;
    if (is_ok) begin
      issue_res.frame_type    = cmd_q.frame_type;
      issue_res.payload_size  = cmd_q.size[5:0];
      issue_res.payload_valid = has_data;
      issue_res.byte_position = has_data ? idx_w[4:0] : 5'd0;
    end
  end

  always_comb begin
    s1_out              = s1_res_q;
    s1_out.payload_byte = s1_res_q.payload_valid ? rdata_q : 8'h00;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (issue && has_data) rdata_q <= mem[idx_q[AW-1:0]];
    if (issue) s1_res_q <= issue_res;
    if (cmd_pop_o) cmd_q <= cmd_i;
    if (s1_valid_q) fifo_q[wr_ptr_q] <= s1_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      idx_q      <= '0;
      s1_valid_q <= 1'b0;
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      count_q    <= 2'd0;
    end else begin
      s1_valid_q <= issue;
      if (cmd_pop_o) begin
        active_q <= 1'b1;
        idx_q    <= '0;
      end else if (issue) begin
        idx_q <= CW'(idx_q + 1'b1);
        if (is_last) active_q <= 1'b0;
      end
      if (s1_valid_q) wr_ptr_q <= ~wr_ptr_q;
      if (pop_fire) rd_ptr_q <= ~rd_ptr_q;
      count_q <= 2'(count_q + 2'(s1_valid_q) - 2'(pop_fire));
    end
  end

  assign empty_o = (count_q == 2'd0);
  assign res_o   = fifo_q[rd_ptr_q];

endmodule

@@ rtl/binary_frame_deframer_core.sv @@
// ----------------------------------------------------------------------------
// Binary frame deframer core
// Recovers framed payloads from a received byte stream and reports each
// frame as a run of result items or as one error status.
// ----------------------------------------------------------------------------
// Bytes enter through a queue-style port (push/full) and results leave
// through another (empty/pop). A frame is FE FD, a big-endian 16-bit size,
// a type byte, size payload bytes, a 00 standard byte and the footer FD FE.
// A good frame yields one item per payload byte with last set on the final
// one, or one item with payload_valid low when the size is zero. A bad
// standard byte, a bad footer or a size above MAX_PAYLOAD yields one item
// with the error status and last set; a bad second header byte silently
// returns to the hunt. Normally one byte is accepted per cycle. The parser
// and the result stage share a single payload buffer, so full stays high
// while the parser sits in the payload phase of a frame and the previous
// frame's results have not all been read out of that buffer; full is also
// high while the two-entry command queue between the halves is full. The
// back end loads each frame command and then issues one item per cycle
// while pop keeps up. Results pass through a registered buffer read and a
// two-entry output queue.
`include "binary_frame_deframer_core_assert.svh"

module binary_frame_deframer_core #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] status_o,
  output logic [7:0] frame_type_o,
  output logic [5:0] payload_size_o,
  output logic       payload_valid_o,
  output logic [7:0] payload_byte_o,
  output logic [4:0] byte_position_o,
  output logic       last_o
);

  // Counter width holds the size itself; address width indexes the buffer.
  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic             cmdq_full, back_busy, cmd_push, cmd_valid, cmd_pop;
  bfd_pkg::cmd_t    cmd_in, cmd_head;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_data;
  bfd_pkg::result_t res;

  // The front end parses one byte per accepted item.
  bfd_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .CW         (CW),
    .AW         (AW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .rx_byte_i  (rx_byte_i),
    .cmdq_full_i(cmdq_full),
    .back_busy_i(back_busy),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data)
  );

  // Finished and broken frames wait here until the back end picks them up.
  bfd_cmdq u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (cmdq_full),
    .valid_o(cmd_valid),
    .pop_i  (cmd_pop),
    .data_o (cmd_head)
  );

  // The back end owns the payload buffer and the result queue.
  bfd_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .CW         (CW),
    .AW         (AW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd_head),
    .cmd_pop_o  (cmd_pop),
    .busy_o     (back_busy),
    .pop_i      (pop),
    .empty_o    (empty),
    .res_o      (res)
  );

  assign status_o        = res.status;
  assign frame_type_o    = res.frame_type;
  assign payload_size_o  = res.payload_size;
  assign payload_valid_o = res.payload_valid;
  assign payload_byte_o  = res.payload_byte;
  assign byte_position_o = res.byte_position;
  assign last_o          = res.last;

  // The parser must never overwrite the buffer while a frame is read out.
  `BFD_ASSERT_IMP(a_no_write_while_busy, clk_i, rst_ni, wr_en, !back_busy)
  // A command is never posted into a full queue.
  `BFD_ASSERT_IMP(a_cmd_has_room, clk_i, rst_ni, cmd_push, !cmdq_full)
  // Error items always close their run.
  `BFD_ASSERT_IMP(a_error_is_last, clk_i, rst_ni,
                  !empty && (status_o != bfd_pkg::ST_OK), last_o)
  // A loaded command keeps the back end busy in the next cycle.
  `BFD_ASSERT_NXT(a_pop_makes_busy, clk_i, rst_ni, cmd_pop, back_busy)

endmodule
